// ----- rtl/mqtt_pkg.sv -----
package mqtt_pkg;

  localparam int LENGTH_BITS = 28;
  localparam int ACC_BITS    = 28;
  localparam int LIMIT_BITS  = 28;

  localparam logic [ACC_BITS-1:0] LEN_MAX =
    ACC_BITS'((64'd1 << LENGTH_BITS) - 64'd1);
  localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = LIMIT_BITS'(1048576);

  localparam logic [3:0] PKT_PUBLISH = 4'd3;

  localparam logic [2:0] ROLE_HEADER    = 3'd0;
  localparam logic [2:0] ROLE_LENGTH    = 3'd1;
  localparam logic [2:0] ROLE_TOPIC_LEN = 3'd2;
  localparam logic [2:0] ROLE_TOPIC     = 3'd3;
  localparam logic [2:0] ROLE_PACKET_ID = 3'd4;
  localparam logic [2:0] ROLE_PAYLOAD   = 3'd5;
  localparam logic [2:0] ROLE_OTHER     = 3'd6;
  localparam logic [2:0] ROLE_ERROR     = 3'd7;

  localparam logic [1:0] ERR_NONE      = 2'd0;
  localparam logic [1:0] ERR_TOO_LONG  = 2'd1;
  localparam logic [1:0] ERR_LIMIT     = 2'd2;
  localparam logic [1:0] ERR_MALFORMED = 2'd3;

  typedef enum logic [1:0] {
    PH_HEADER,
    PH_LENGTH,
    PH_BODY,
    PH_ERROR
  } phase_t;

  typedef struct packed {
    logic [2:0]  byte_role;
    logic [7:0]  data_byte;
    logic [3:0]  packet_type;
    logic [1:0]  qos_level;
    logic [15:0] topic_size;
    logic        last_of_packet;
    logic [1:0]  error_code;
  } result_t;

endpackage

// ----- rtl/mqtt_ifs.sv -----
interface mqtt_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface mqtt_result_if;
  logic        valid;
  logic        ready;
  logic [2:0]  byte_role;
  logic [7:0]  data_byte;
  logic [3:0]  packet_type;
  logic [1:0]  qos_level;
  logic [15:0] topic_size;
  logic        last_of_packet;
  logic [1:0]  error_code;

  modport source (
    output valid, output byte_role, output data_byte, output packet_type,
    output qos_level, output topic_size, output last_of_packet, output error_code,
    input ready
  );
  modport sink (
    input valid, input byte_role, input data_byte, input packet_type,
    input qos_level, input topic_size, input last_of_packet, input error_code,
    output ready
  );
endinterface

interface mqtt_cfg_if;
  logic        valid;
  logic        ready;
  logic [27:0] max_remaining_length;

  modport source (output valid, output max_remaining_length, input ready);
  modport sink (input valid, input max_remaining_length, output ready);
endinterface

// ----- rtl/mqtt_parser.sv -----
module mqtt_parser import mqtt_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  step,
  input  logic [7:0]            rx_byte,
  input  logic [LIMIT_BITS-1:0] limit,
  output result_t               res
);

  phase_t                 phase, phase_next;
  logic [7:0]             header_reg, header_next;
  logic [LENGTH_BITS-1:0] length_accum, length_accum_next;
  logic [1:0]             length_byte_count, length_byte_count_next;
  logic [LENGTH_BITS-1:0] body_count, body_count_next;
  logic [15:0]            topic_len_reg, topic_len_next;
  logic                   malformed_flag, malformed_next;
  logic [1:0]             sticky_error, sticky_error_next;

  logic [3:0]             typ;
  logic [1:0]             qos;
  logic                   pub;
  logic [4:0]             shamt;
  logic [ACC_BITS-1:0]    acc;
  logic [LENGTH_BITS-1:0] acc_len;
  logic                   over_width;
  logic                   over_limit;
  logic                   cont;
  logic                   too_long;
  logic [LENGTH_BITS-1:0] idx_inc;
  logic [LENGTH_BITS-1:0] topic_ext;
  logic                   body_last;

  assign typ = header_reg[7:4];
  assign qos = header_reg[2:1];
  assign pub = (typ == PKT_PUBLISH);

  // length group weight: 7 bits per byte already seen
  always_comb begin
    case (length_byte_count)
      2'd0:    shamt = 5'd0;
      2'd1:    shamt = 5'd7;
      2'd2:    shamt = 5'd14;
      default: shamt = 5'd21;
    endcase
  end

  assign acc        = ACC_BITS'(length_accum) + (ACC_BITS'(rx_byte[6:0]) << shamt);
  assign acc_len    = acc[LENGTH_BITS-1:0];
  assign over_width = (acc > LEN_MAX);
  assign over_limit = (LIMIT_BITS'(acc_len) > limit);
  assign cont       = rx_byte[7];
  assign too_long   = (length_byte_count == 2'd3);

  assign idx_inc   = body_count + LENGTH_BITS'(1);
  assign topic_ext = LENGTH_BITS'(topic_len_reg);
  assign body_last = (idx_inc >= length_accum);

  always_comb begin
    phase_next = phase;
    unique case (phase)
      PH_HEADER: phase_next = PH_LENGTH;
      PH_LENGTH: begin
        if (over_width) begin
          phase_next = PH_ERROR;
        end else if (cont) begin
          if (too_long) phase_next = PH_ERROR;
        end else if (over_limit) begin
          phase_next = PH_ERROR;
        end else if (acc_len == '0) begin
          phase_next = PH_HEADER;
        end else begin
          phase_next = PH_BODY;
        end
      end
      PH_BODY: begin
        if (body_last) phase_next = PH_HEADER;
      end
      PH_ERROR: phase_next = PH_ERROR;
      default: phase_next = PH_ERROR;
    endcase
  end

  always_comb begin
    logic [17:0] need;
    header_next            = header_reg;
    length_accum_next      = length_accum;
    length_byte_count_next = length_byte_count;
    body_count_next        = body_count;
    topic_len_next         = topic_len_reg;
    malformed_next         = malformed_flag;
    sticky_error_next      = sticky_error;
    need                   = '0;

    res.byte_role      = ROLE_ERROR;
    res.data_byte      = rx_byte;
    res.packet_type    = typ;
    res.qos_level      = qos;
    res.topic_size     = '0;
    res.last_of_packet = 1'b0;
    res.error_code     = ERR_NONE;

    unique case (phase)
      PH_HEADER: begin
        header_next            = rx_byte;
        length_accum_next      = '0;
        length_byte_count_next = '0;
        body_count_next        = '0;
        topic_len_next         = '0;
        malformed_next         = 1'b0;
        res.byte_role          = ROLE_HEADER;
        res.packet_type        = rx_byte[7:4];
        res.qos_level          = rx_byte[2:1];
      end
      PH_LENGTH: begin
        res.byte_role = ROLE_LENGTH;
        if (over_width || (cont && too_long) || (!cont && over_limit)) begin
          sticky_error_next = (cont && too_long && !over_width) ? ERR_TOO_LONG : ERR_LIMIT;
          res.byte_role     = ROLE_ERROR;
          res.packet_type   = '0;
          res.qos_level     = '0;
          res.error_code    = sticky_error_next;
        end else begin
          length_accum_next = acc_len;
          if (cont) begin
            length_byte_count_next = length_byte_count + 2'd1;
          end else if (acc_len == '0) begin
            res.last_of_packet = 1'b1;
            res.error_code     = pub ? ERR_MALFORMED : ERR_NONE;
          end else begin
            body_count_next = '0;
            topic_len_next  = '0;
            malformed_next  = 1'b0;
          end
        end
      end
      PH_BODY: begin
        if (!pub) begin
          res.byte_role = ROLE_OTHER;
        end else if (body_count == '0) begin
          res.byte_role  = ROLE_TOPIC_LEN;
          topic_len_next = {rx_byte, 8'h00};
        end else if (body_count == LENGTH_BITS'(1)) begin
          res.byte_role  = ROLE_TOPIC_LEN;
          topic_len_next = {topic_len_reg[15:8], rx_byte};
          need = 18'd2 + 18'(topic_len_next) + ((qos != 2'd0) ? 18'd2 : 18'd0);
          if (LENGTH_BITS'(need) > length_accum) malformed_next = 1'b1;
        end else if (body_count < topic_ext + LENGTH_BITS'(2)) begin
          res.byte_role = ROLE_TOPIC;
        end else if (qos != 2'd0 && body_count < topic_ext + LENGTH_BITS'(4)) begin
          res.byte_role = ROLE_PACKET_ID;
        end else begin
          res.byte_role = ROLE_PAYLOAD;
        end
        if (pub && body_count != '0) res.topic_size = topic_len_next;
        body_count_next    = idx_inc;
        res.last_of_packet = body_last;
        if (body_last && pub && (length_accum < LENGTH_BITS'(2) || malformed_next)) begin
          res.error_code = ERR_MALFORMED;
        end
      end
      PH_ERROR: begin
        res.packet_type = '0;
        res.qos_level   = '0;
        res.error_code  = sticky_error;
      end
      default: begin
        res.packet_type = '0;
        res.qos_level   = '0;
        res.error_code  = sticky_error;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= PH_HEADER;
      header_reg        <= '0;
      length_accum      <= '0;
      length_byte_count <= '0;
      body_count        <= '0;
      topic_len_reg     <= '0;
      malformed_flag    <= 1'b0;
      sticky_error      <= ERR_NONE;
    end else if (step) begin
      phase             <= phase_next;
      header_reg        <= header_next;
      length_accum      <= length_accum_next;
      length_byte_count <= length_byte_count_next;
      body_count        <= body_count_next;
      topic_len_reg     <= topic_len_next;
      malformed_flag    <= malformed_next;
      sticky_error      <= sticky_error_next;
    end
  end

`ifndef SYNTHESIS
  a_error_sticks: assert property (@(posedge clk) disable iff (rst)
    phase == PH_ERROR |=> phase == PH_ERROR)
    else $error("left sticky error phase");

  a_header_not_last: assert property (@(posedge clk) disable iff (rst)
    step && phase == PH_HEADER |-> !res.last_of_packet)
    else $error("header beat flagged as last");

  a_error_role_locks: assert property (@(posedge clk) disable iff (rst)
    step && res.byte_role == ROLE_ERROR |=> phase == PH_ERROR)
    else $error("error beat did not lock the parser");
`endif

endmodule

// ----- rtl/mqtt_packet_deframer.sv -----
// MQTT packet deframer.
// stream: one received byte per beat (valid/ready, rx_byte).
// result: one beat per input byte, carrying the byte's role, the byte itself,
//   packet type, qos, topic length of a PUBLISH, end-of-packet flag and
//   error code.
// cfg: write-only channel for max_remaining_length; always ready, to be
//   written only while the block is idle.
// Output: a byte's result is registered and shown in the cycle after its beat.
// Throughput: one byte per cycle unless stalled; the per-byte state update
//   is one registered step (length add, compare), then the result register.
// Reset: parser back to awaiting a fixed header, sticky error cleared,
//   limit set to 1048576, no result pending.
// Stall: the result register holds one finished result; a new byte is taken
//   in the cycle the held result is taken, so stream.ready follows
//   result.ready while a result is pending.
// A remaining length over the limit or a continuation bit on a fourth length
//   byte locks the block in error (role 7) until reset.
module mqtt_packet_deframer import mqtt_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  mqtt_cfg_if.sink      cfg,
  mqtt_byte_if.sink     stream,
  mqtt_result_if.source result
);

  logic [LIMIT_BITS-1:0] limit;
  logic                  step;
  logic                  out_valid;
  result_t               res;
  result_t               out_reg;

  assign cfg.ready    = 1'b1;
  assign stream.ready = !out_valid || result.ready;
  assign step         = stream.valid && stream.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      limit <= LIMIT_RESET;
    end else if (cfg.valid) begin
      limit <= cfg.max_remaining_length;
    end
  end

  mqtt_parser u_parser (
    .clk     (clk),
    .rst     (rst),
    .step    (step),
    .rx_byte (stream.rx_byte),
    .limit   (limit),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) out_reg <= res;
  end

  assign result.valid          = out_valid;
  assign result.byte_role      = out_reg.byte_role;
  assign result.data_byte      = out_reg.data_byte;
  assign result.packet_type    = out_reg.packet_type;
  assign result.qos_level      = out_reg.qos_level;
  assign result.topic_size     = out_reg.topic_size;
  assign result.last_of_packet = out_reg.last_of_packet;
  assign result.error_code     = out_reg.error_code;

`ifndef SYNTHESIS
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    !stream.ready |-> result.valid && !result.ready)
    else $error("input stalled with room in result register");

  a_beat_gives_result: assert property (@(posedge clk) disable iff (rst)
    stream.valid && stream.ready |=> result.valid)
    else $error("accepted beat produced no result");

  a_error_role_has_code: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.byte_role == ROLE_ERROR |-> result.error_code != ERR_NONE)
    else $error("error role without error code");
`endif

endmodule
